@@ design/frm_pkg.sv @@
// Package for the frame RMS level meter: widths, limits, queue sizing,
// the frame record type and the back-end state type.
// Used by every module of the block; depends on nothing.
`default_nettype none

package frm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 16;
  localparam int LEVEL_W  = 16;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SREM_W   = ROOT_W + 2;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'd512;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [ROOT_W-1:0]  FULL_SCALE  = 20'd32768;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'(ROOT_W - 1);

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ design/frame_rms_level_meter.sv @@
// Frame RMS level meter, top level.
// Channels: the slave stream takes one sample per transaction. s_tdata[15:0]
// is the signed sample, s_tuser is the mode flag (1 marks an empty frame and
// yields level 0 with count 0), s_tlast marks the final sample of a frame.
// The master stream gives one transaction per finished frame: m_tdata[15:0]
// is the RMS level (32768 is full scale) and m_tdata[31:16] the sample count.
// Throughput: one sample per cycle while s_tready is high. Per frame the back
// end does a bit-serial divide, a bit-serial square root and hand-off through
// its IDLE and DONE states. A four-entry queue of frame records sits between
// front and back, so the front end goes on taking samples while the back end
// works on earlier frames. A result passes the squarer register, the queue
// and the back-end states to m_tvalid; an empty-frame marker skips DIV and SQRT.
// When the receiver holds m_tready low the result stays in the output
// register, the back end waits, the queue fills and then s_tready drops.
// Reset (rst, synchronous) clears the accumulators, the queue and m_tvalid.
// Depends on frm_pkg, frm_front, frm_queue and frm_back.
`default_nettype none

module frame_rms_level_meter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // [15:0] sample
  input  wire logic         s_tuser,   // [0] mode
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [31:0]       m_tdata    // [15:0] level, [31:16] sample_count
);

  frm_pkg::push_t                 push;
  frm_pkg::frame_t                head;
  logic                           head_valid;
  logic                           pop;
  logic [frm_pkg::QLVL_W-1:0]     q_level;

  frm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_level  (q_level),
    .push     (push)
  );

  frm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  frm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

@@ design/frm_front.sv @@
// Front end of the level meter: accepts sample transactions, squares them
// and keeps the per-frame sum of squares and count. Depends on frm_pkg.
`default_nettype none

module frm_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [frm_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  wire logic                           s_tuser,   // [0] mode
  input  wire logic                           s_tlast,   // last
  input  wire logic [frm_pkg::QLVL_W-1:0]     q_level,
  output frm_pkg::push_t                      push
);

  logic                         sq_valid;
  logic                         sq_mode;
  logic                         sq_last;
  logic [frm_pkg::SQ_W-1:0]     sq;
  logic [frm_pkg::SUM_W-1:0]    sum;
  logic [frm_pkg::COUNT_W-1:0]  count;

  logic [frm_pkg::SUM_W-1:0]    sum_next;
  logic [frm_pkg::COUNT_W-1:0]  count_next;
  logic [frm_pkg::SUM_W-1:0]    sum_acc;
  logic [frm_pkg::COUNT_W-1:0]  count_acc;
  logic [frm_pkg::SUM_W:0]      sum_add;
  logic signed [2*frm_pkg::SAMPLE_W-1:0] prod;
  logic [frm_pkg::QLVL_W:0]     reserved;
  logic                         accept;

  assign reserved = {1'b0, q_level} + {{frm_pkg::QLVL_W{1'b0}}, sq_valid};
  assign s_tready = reserved < (frm_pkg::QLVL_W+1)'(frm_pkg::QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign prod     = $signed(s_tdata) * $signed(s_tdata);

  always_comb begin
    sum_add = {1'b0, sum} + {{(frm_pkg::SUM_W + 1 - frm_pkg::SQ_W){1'b0}}, sq};
    if (count < frm_pkg::MAX_SAMPLES) begin
      sum_acc = sum_add[frm_pkg::SUM_W] ? {frm_pkg::SUM_W{1'b1}}
                                         : sum_add[frm_pkg::SUM_W-1:0];
    end else begin
      sum_acc = sum;
    end
    count_acc = (count == frm_pkg::COUNT_MAX) ? count : count + 1'b1;

    push.valid       = sq_valid && (sq_mode || sq_last);
    push.frame.sum   = sq_mode ? '0 : sum_acc;
    push.frame.count = sq_mode ? '0 : count_acc;

    sum_next   = sum;
    count_next = count;
    if (sq_valid) begin
      if (sq_mode || sq_last) begin
        sum_next   = '0;
        count_next = '0;
      end else begin
        sum_next   = sum_acc;
        count_next = count_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sum      <= '0;
      count    <= '0;
    end else begin
      sq_valid <= accept;
      sum      <= sum_next;
      count    <= count_next;
    end
    if (accept) begin
      sq_mode <= s_tuser;
      sq_last <= s_tlast;
      sq      <= prod[frm_pkg::SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/frm_queue.sv @@
// Short register queue of finished frame records between the front end
// and the back end of the level meter. Depends on frm_pkg.
`default_nettype none

module frm_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire frm_pkg::push_t              push,
  input  wire logic                        pop,
  output frm_pkg::frame_t                  head,
  output logic                             head_valid,
  output logic [frm_pkg::QLVL_W-1:0]       level
);

  frm_pkg::frame_t              entries [frm_pkg::QUEUE_DEPTH];
  logic [frm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [frm_pkg::QPTR_W-1:0]   rd_ptr;
  logic                         do_pop;

  assign head_valid = level != '0;
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + {{(frm_pkg::QLVL_W-1){1'b0}}, push.valid}
                     - {{(frm_pkg::QLVL_W-1){1'b0}}, do_pop};
    end
    if (push.valid) begin
      entries[wr_ptr] <= push.frame;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> level < frm_pkg::QLVL_W'(frm_pkg::QUEUE_DEPTH))
    else $error("frame queue written while full");

endmodule

`default_nettype wire

@@ design/frm_back.sv @@
// Back end of the level meter: takes frame records from the queue, divides
// the sum of squares by the count one bit a cycle, takes the integer square
// root one bit a cycle, clamps and holds the result. Depends on frm_pkg.
`default_nettype none

module frm_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire frm_pkg::frame_t                     head,
  input  wire logic                                head_valid,
  output logic                                     pop,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [frm_pkg::LEVEL_W+frm_pkg::COUNT_W-1:0] m_tdata  // [15:0] level,
                                                                // [31:16] sample_count
);

  frm_pkg::back_state_t          state;
  frm_pkg::back_state_t          state_next;
  logic [frm_pkg::STEP_W-1:0]    step;
  logic [frm_pkg::COUNT_W-1:0]   divisor;
  logic [frm_pkg::SUM_W-1:0]     quot;
  logic [frm_pkg::COUNT_W-1:0]   rem;
  logic [frm_pkg::ROOT_W-1:0]    root;
  logic [frm_pkg::SREM_W-1:0]    srem;
  logic                          load_out;

  logic [frm_pkg::COUNT_W:0]     rem_sh;
  logic [frm_pkg::COUNT_W:0]     rem_dif;
  logic                          div_ge;
  logic [frm_pkg::SREM_W+1:0]    srem_sh;
  logic [frm_pkg::SREM_W+1:0]    trial;
  logic [frm_pkg::SREM_W+1:0]    srem_dif;
  logic                          sqrt_ge;
  logic [frm_pkg::ROOT_W-1:0]    level_clamped;

  assign rem_sh   = {rem, quot[frm_pkg::SUM_W-1]};
  assign rem_dif  = rem_sh - {1'b0, divisor};
  assign div_ge   = rem_sh >= {1'b0, divisor};
  assign srem_sh  = {srem, quot[frm_pkg::SUM_W-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign srem_dif = srem_sh - trial;
  assign sqrt_ge  = srem_sh >= trial;
  assign level_clamped = (root > frm_pkg::FULL_SCALE) ? frm_pkg::FULL_SCALE : root;

  always_comb begin
    state_next = state;
    case (state)
      frm_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_next = (head.count == '0) ? frm_pkg::ST_DONE : frm_pkg::ST_DIV;
        end
      end
      frm_pkg::ST_DIV: begin
        if (step == frm_pkg::DIV_LAST) begin
          state_next = frm_pkg::ST_SQRT;
        end
      end
      frm_pkg::ST_SQRT: begin
        if (step == frm_pkg::SQRT_LAST) begin
          state_next = frm_pkg::ST_DONE;
        end
      end
      frm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = frm_pkg::ST_IDLE;
        end
      end
      default: state_next = frm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      frm_pkg::ST_IDLE: pop      = head_valid;
      frm_pkg::ST_DONE: load_out = !m_tvalid || m_tready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= frm_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    case (state)
      frm_pkg::ST_IDLE: begin
        step    <= '0;
        divisor <= head.count;
        quot    <= head.sum;
        rem     <= '0;
        root    <= '0;
        srem    <= '0;
      end
      frm_pkg::ST_DIV: begin
        rem  <= div_ge ? rem_dif[frm_pkg::COUNT_W-1:0] : rem_sh[frm_pkg::COUNT_W-1:0];
        quot <= {quot[frm_pkg::SUM_W-2:0], div_ge};
        step <= (step == frm_pkg::DIV_LAST) ? '0 : step + 1'b1;
      end
      frm_pkg::ST_SQRT: begin
        srem <= sqrt_ge ? srem_dif[frm_pkg::SREM_W-1:0] : srem_sh[frm_pkg::SREM_W-1:0];
        root <= {root[frm_pkg::ROOT_W-2:0], sqrt_ge};
        quot <= {quot[frm_pkg::SUM_W-3:0], 2'b00};
        step <= step + 1'b1;
      end
      default: begin
        step <= step;
      end
    endcase

    if (load_out) begin
      m_tdata <= {divisor, level_clamped[frm_pkg::LEVEL_W-1:0]};
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[frm_pkg::LEVEL_W-1:0] <= frm_pkg::FULL_SCALE[frm_pkg::LEVEL_W-1:0])
    else $error("level above full scale");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == frm_pkg::ST_DIV |-> divisor != '0)
    else $error("division started with a zero count");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != frm_pkg::ST_IDLE)
    else $error("frame taken from the queue but back end stayed idle");

endmodule

`default_nettype wire
